@@ hdl/ted_pkg.sv @@
// Package for the text encoding detector: result struct, class codes and byte constants.
// No dependencies; imported by ted_scan and text_encoding_detector_top.
`default_nettype none
package ted_pkg;

  typedef enum logic [2:0] {
    CLS_UTF8_BOM  = 3'd0,
    CLS_UTF16LE   = 3'd1,
    CLS_UTF16BE   = 3'd2,
    CLS_UTF8      = 3'd3,
    CLS_LOCALE    = 3'd4
  } ted_class_e;

  typedef struct packed {
    ted_class_e  enc_class;
    logic [1:0]  offset;
    logic        utf8_valid;
  } ted_result_t;

  localparam logic [7:0] BomUtf8B0  = 8'hEF;
  localparam logic [7:0] BomUtf8B1  = 8'hBB;
  localparam logic [7:0] BomUtf8B2  = 8'hBF;
  localparam logic [7:0] BomHigh    = 8'hFF;
  localparam logic [7:0] BomLow     = 8'hFE;
  localparam logic [7:0] Lead2Min   = 8'hC2;
  localparam logic [7:0] Lead4Max   = 8'hF4;

  localparam logic [1:0] OffsetUtf8Bom  = 2'd3;
  localparam logic [1:0] OffsetUtf16Bom = 2'd2;
  localparam logic [1:0] OffsetNone     = 2'd0;

endpackage
`default_nettype wire

@@ hdl/ted_scan.sv @@
// Per-file scan state: first three bytes, byte count, owed continuations, sticky error.
// Computes the result for a final byte combinationally. Depends on ted_pkg.
`default_nettype none
module ted_scan import ted_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        step_i,
  input  wire logic [7:0]  byte_i,
  input  wire logic        last_i,
  output ted_result_t      result_o
);

  logic [23:0] head_q, head_d;
  logic [1:0]  count_q, count_d;
  logic [1:0]  pend_q, pend_n, pend_d;
  logic        inv_q, inv_n, inv_d;
  logic        valid_f;
  logic [7:0]  b0, b1, b2;

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    unique case (count_q)
      2'd0:    head_d[7:0]   = byte_i;
      2'd1:    head_d[15:8]  = byte_i;
      2'd2:    head_d[23:16] = byte_i;
      default: head_d        = head_q;
    endcase
    if (count_q != 2'd3) begin
      count_d = count_q + 2'd1;
    end

    pend_n = pend_q;
    inv_n  = inv_q;
    if (pend_q != 2'd0) begin
      if (byte_i[7:6] != 2'b10) begin
        inv_n = 1'b1;
      end
      pend_n = pend_q - 2'd1;
    end else if (byte_i[7] == 1'b0) begin
      pend_n = 2'd0;
    end else if (byte_i[7:5] == 3'b110) begin
      if (byte_i < Lead2Min) begin
        inv_n = 1'b1;
      end else begin
        pend_n = 2'd1;
      end
    end else if (byte_i[7:4] == 4'b1110) begin
      pend_n = 2'd2;
    end else if (byte_i[7:3] == 5'b11110) begin
      if (byte_i > Lead4Max) begin
        inv_n = 1'b1;
      end else begin
        pend_n = 2'd3;
      end
    end else begin
      inv_n = 1'b1;
    end

    valid_f = !(inv_n || (pend_n != 2'd0));
    b0 = head_d[7:0];
    b1 = head_d[15:8];
    b2 = head_d[23:16];

    result_o.utf8_valid = valid_f;
    if (count_d == 2'd3 && b0 == BomUtf8B0 && b1 == BomUtf8B1 && b2 == BomUtf8B2) begin
      result_o.enc_class = CLS_UTF8_BOM;
      result_o.offset    = OffsetUtf8Bom;
    end else if (count_d >= 2'd2 && b0 == BomHigh && b1 == BomLow) begin
      result_o.enc_class = CLS_UTF16LE;
      result_o.offset    = OffsetUtf16Bom;
    end else if (count_d >= 2'd2 && b0 == BomLow && b1 == BomHigh) begin
      result_o.enc_class = CLS_UTF16BE;
      result_o.offset    = OffsetUtf16Bom;
    end else if (valid_f) begin
      result_o.enc_class = CLS_UTF8;
      result_o.offset    = OffsetNone;
    end else begin
      result_o.enc_class = CLS_LOCALE;
      result_o.offset    = OffsetNone;
    end

    pend_d = pend_n;
    inv_d  = inv_n;
    if (last_i) begin
      head_d  = '0;
      count_d = 2'd0;
      pend_d  = 2'd0;
      inv_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= 2'd0;
      pend_q  <= 2'd0;
      inv_q   <= 1'b0;
    end else if (step_i) begin
      head_q  <= head_d;
      count_q <= count_d;
      pend_q  <= pend_d;
      inv_q   <= inv_d;
    end
  end

endmodule
`default_nettype wire

@@ hdl/text_encoding_detector_top.sv @@
// Top level of the text encoding detector: input register, scan logic, result register.
// Depends on ted_pkg and ted_scan.
// Throughput: one byte per cycle; a stalled result holds only the final byte behind it.
// The final byte passes through the input register, then its result is captured in the result register once it is free.
// Reset clears the scan state and both valid flags; the first byte starts a new file.
`default_nettype none
module text_encoding_detector_top import ted_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output      logic        in_ready_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        final_byte_i,
  output      logic        out_valid_o,
  input  wire logic        out_ready_i,
  output      logic [2:0]  encoding_class_o,
  output      logic [1:0]  payload_offset_o,
  output      logic        utf8_valid_o
);

  logic        in_valid_q;
  logic [7:0]  byte_q;
  logic        last_q;
  logic        out_valid_q;
  ted_result_t res_q;
  ted_result_t res_d;
  logic        out_free;
  logic        advance;

  assign out_free   = !out_valid_q || out_ready_i;
  assign advance    = in_valid_q && (!last_q || out_free);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= data_byte_i;
      last_q <= final_byte_i;
    end
  end

  ted_scan u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .byte_i   (byte_q),
    .last_i   (last_q),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= advance && last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && advance && last_q) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign encoding_class_o = res_q.enc_class;
  assign payload_offset_o = res_q.offset;
  assign utf8_valid_o     = res_q.utf8_valid;

  a_held_item_stays : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(byte_q) && $stable(last_q))
    else $error("held input item changed");

  a_bom_offset : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.enc_class == CLS_UTF8_BOM |-> res_q.offset == OffsetUtf8Bom)
    else $error("UTF-8 mark without offset three");

  a_plain_class_validity : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (res_q.enc_class == CLS_UTF8 || res_q.enc_class == CLS_LOCALE)
    |-> res_q.offset == OffsetNone && (res_q.utf8_valid == (res_q.enc_class == CLS_UTF8)))
    else $error("unmarked class disagrees with validity");

  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |-> !(advance && last_q))
    else $error("final byte advanced into an occupied result register");

endmodule
`default_nettype wire

@@ bench/tb_text_encoding_detector_top.sv @@
// Testbench for text_encoding_detector_top: sends whole files byte by byte and checks each
// file's class, mark offset and UTF-8 verdict against a directed table entry or an in-bench predictor.
// Depends on ted_pkg and the RTL under hdl/.
module tb_text_encoding_detector_top;
  import ted_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ItemTarget   = 1150;
  localparam int HoldCycles   = 300;
  localparam int StallLimit   = 2000;
  localparam int DrainCycles  = 8;

  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic        typed;
    ted_result_t want;
  } byte_row_t;

  localparam ted_result_t NoResult = '{CLS_LOCALE, OffsetNone, 1'b0};

  localparam byte_row_t DirectedBytes [25] = '{
    '{8'hEF, 1'b0, 1'b0, NoResult},
    '{8'hBB, 1'b0, 1'b0, NoResult},
    '{8'hBF, 1'b1, 1'b1, '{CLS_UTF8_BOM, OffsetUtf8Bom, 1'b1}},
    '{8'hFF, 1'b0, 1'b0, NoResult},
    '{8'hFE, 1'b1, 1'b1, '{CLS_UTF16LE, OffsetUtf16Bom, 1'b0}},
    '{8'hFE, 1'b0, 1'b0, NoResult},
    '{8'hFF, 1'b1, 1'b1, '{CLS_UTF16BE, OffsetUtf16Bom, 1'b0}},
    '{8'h00, 1'b1, 1'b1, '{CLS_UTF8, OffsetNone, 1'b1}},
    '{8'hFF, 1'b1, 1'b1, '{CLS_LOCALE, OffsetNone, 1'b0}},
    '{8'hC0, 1'b0, 1'b0, NoResult},
    '{8'h80, 1'b1, 1'b1, '{CLS_LOCALE, OffsetNone, 1'b0}},
    '{8'hC2, 1'b0, 1'b0, NoResult},
    '{8'hBF, 1'b1, 1'b0, NoResult},
    '{8'hF4, 1'b0, 1'b0, NoResult},
    '{8'h8F, 1'b0, 1'b0, NoResult},
    '{8'hBF, 1'b0, 1'b0, NoResult},
    '{8'hBF, 1'b1, 1'b0, NoResult},
    '{8'hE0, 1'b0, 1'b0, NoResult},
    '{8'h80, 1'b1, 1'b1, '{CLS_LOCALE, OffsetNone, 1'b0}},
    '{8'hF5, 1'b1, 1'b1, '{CLS_LOCALE, OffsetNone, 1'b0}},
    '{8'hE1, 1'b0, 1'b0, NoResult},
    '{8'h41, 1'b0, 1'b0, NoResult},
    '{8'h80, 1'b1, 1'b0, NoResult},
    '{8'hEF, 1'b0, 1'b0, NoResult},
    '{8'hBB, 1'b1, 1'b1, '{CLS_LOCALE, OffsetNone, 1'b0}}
  };

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [7:0] data_byte_i;
  logic       final_byte_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [2:0] encoding_class_o;
  logic [1:0] payload_offset_o;
  logic       utf8_valid_o;

  logic [23:0] hdr_q;
  logic [1:0]  hdr_cnt_q;
  logic [1:0]  owed_q;
  logic        broken_q;

  ted_result_t expected_verdicts[$];
  int          n_errors;
  int          n_sent;
  int          tx_idle_pct;
  int          rx_idle_pct;
  bit          hold_out;

  text_encoding_detector_top DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .data_byte_i      (data_byte_i),
    .final_byte_i     (final_byte_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .encoding_class_o (encoding_class_o),
    .payload_offset_o (payload_offset_o),
    .utf8_valid_o     (utf8_valid_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic bit predict_byte(input logic [7:0] b, input logic last,
                                      output ted_result_t res);
    logic ok;
    res = NoResult;
    if (hdr_cnt_q < 2'd3) begin
      hdr_q[8*hdr_cnt_q +: 8] = b;
      hdr_cnt_q = hdr_cnt_q + 2'd1;
    end
    if (owed_q != 2'd0) begin
      if (b[7:6] != 2'b10) broken_q = 1'b1;
      owed_q = owed_q - 2'd1;
    end else if (b[7]) begin
      if (b[7:5] == 3'b110) begin
        if (b < Lead2Min) broken_q = 1'b1;
        else owed_q = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
        owed_q = 2'd2;
      end else if (b[7:3] == 5'b11110) begin
        if (b > Lead4Max) broken_q = 1'b1;
        else owed_q = 2'd3;
      end else begin
        broken_q = 1'b1;
      end
    end
    if (!last) return 1'b0;
    if (owed_q != 2'd0) broken_q = 1'b1;
    ok = !broken_q;
    if (hdr_cnt_q == 2'd3 && hdr_q == {BomUtf8B2, BomUtf8B1, BomUtf8B0})
      res = '{CLS_UTF8_BOM, OffsetUtf8Bom, ok};
    else if (hdr_cnt_q >= 2'd2 && hdr_q[15:0] == {BomLow, BomHigh})
      res = '{CLS_UTF16LE, OffsetUtf16Bom, ok};
    else if (hdr_cnt_q >= 2'd2 && hdr_q[15:0] == {BomHigh, BomLow})
      res = '{CLS_UTF16BE, OffsetUtf16Bom, ok};
    else if (ok)
      res = '{CLS_UTF8, OffsetNone, ok};
    else
      res = '{CLS_LOCALE, OffsetNone, ok};
    hdr_q = '0;
    hdr_cnt_q = '0;
    owed_q = '0;
    broken_q = 1'b0;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    n_errors++;
  endtask

  task automatic check_result();
    ted_result_t want;
    if (expected_verdicts.size() == 0) begin
      report_mismatch($sformatf("result with no file pending, class %0d", encoding_class_o));
    end else begin
      want = expected_verdicts.pop_front();
      if (encoding_class_o !== want.enc_class)
        report_mismatch($sformatf("class %0d, want %0d", encoding_class_o, want.enc_class));
      if (payload_offset_o !== want.offset)
        report_mismatch($sformatf("offset %0d, want %0d", payload_offset_o, want.offset));
      if (utf8_valid_o !== want.utf8_valid)
        report_mismatch($sformatf("utf8_valid %0b, want %0b", utf8_valid_o, want.utf8_valid));
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last, input logic typed,
                           input ted_result_t typed_res);
    ted_result_t res;
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid_i   <= 1'b1;
    data_byte_i  <= b;
    final_byte_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    n_sent++;
    if (predict_byte(b, last, res))
      expected_verdicts.push_back(typed ? typed_res : res);
  endtask

  task automatic send_random_file();
    logic [7:0] fbytes[$];
    logic [7:0] lead;
    int         n_chars;
    int         len;
    int         mode;
    int         keep;
    case ($urandom_range(7))
      0: begin
        fbytes.push_back(BomUtf8B0);
        fbytes.push_back(BomUtf8B1);
        fbytes.push_back(BomUtf8B2);
      end
      1: begin
        fbytes.push_back(BomHigh);
        fbytes.push_back(BomLow);
      end
      2: begin
        fbytes.push_back(BomLow);
        fbytes.push_back(BomHigh);
      end
      3: begin
        fbytes.push_back(BomUtf8B0);
        fbytes.push_back(BomUtf8B1);
      end
      default: ;
    endcase
    n_chars = $urandom_range(6);
    repeat (n_chars) begin
      mode = $urandom_range(99);
      len  = $urandom_range(4, 1);
      case (len)
        1:       lead = 8'($urandom_range(8'h7F));
        2:       lead = 8'($urandom_range(8'hDF, Lead2Min));
        3:       lead = 8'($urandom_range(8'hEF, 8'hE0));
        default: lead = 8'($urandom_range(Lead4Max, 8'hF0));
      endcase
      if (mode < 8) lead = 8'($urandom_range(8'hFF));
      fbytes.push_back(lead);
      keep = len - 1;
      if (mode >= 8 && mode < 14 && len > 1) keep = $urandom_range(len - 2);
      for (int i = 0; i < keep; i++) begin
        if (mode >= 14 && mode < 19 && i == 0)
          fbytes.push_back(8'($urandom_range(8'hFF)));
        else
          fbytes.push_back(8'h80 | 8'($urandom_range(8'h3F)));
      end
    end
    if (fbytes.size() == 0) fbytes.push_back(8'($urandom_range(8'hFF)));
    foreach (fbytes[i])
      send_byte(fbytes[i], i == fbytes.size() - 1, 1'b0, NoResult);
  endtask

  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) check_result();
      if (hold_out) begin
        hold_out = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end
      out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("tb_text_encoding_detector_top: FAIL");
        $finish;
      end
    end
  end

  initial begin
    bit pressed;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    data_byte_i  = '0;
    final_byte_i = 1'b0;
    hdr_q        = '0;
    hdr_cnt_q    = '0;
    owed_q       = '0;
    broken_q     = 1'b0;
    n_errors     = 0;
    n_sent       = 0;
    hold_out     = 1'b0;
    pressed      = 1'b0;
    tx_idle_pct  = 12;
    rx_idle_pct  = 65;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (DirectedBytes[i])
      send_byte(DirectedBytes[i].data, DirectedBytes[i].last, DirectedBytes[i].typed,
                DirectedBytes[i].want);

    while (n_sent < ItemTarget) begin
      if (n_sent >= 800 && !pressed) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_out    = 1'b1;
        pressed     = 1'b1;
      end else if (n_sent >= 420 && n_sent < 800) begin
        tx_idle_pct = 65;
        rx_idle_pct = 12;
      end
      send_random_file();
    end
    in_valid_i <= 1'b0;

    while (expected_verdicts.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (n_errors == 0 && expected_verdicts.size() == 0)
      $display("tb_text_encoding_detector_top: PASS");
    else
      $display("tb_text_encoding_detector_top: FAIL");
    $finish;
  end

endmodule
